@@ rtl/core/pe_pkg.sv @@
// Shared constants, types and helpers for the permutation enumerator.
package pe_pkg;

   localparam int MAX_ELEMENTS = 12;
   localparam int NIBBLE_W     = 4;
   localparam int PERM_W       = MAX_ELEMENTS * NIBBLE_W;
   localparam int RANK_W       = 29;
   localparam int SIZE_W       = 4;

   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(4);

   // n! for n = 0..MAX_ELEMENTS
   localparam logic [RANK_W-1:0] FACT_TABLE [0:MAX_ELEMENTS] = '{
      RANK_W'(1),        RANK_W'(1),        RANK_W'(2),         RANK_W'(6),
      RANK_W'(24),       RANK_W'(120),      RANK_W'(720),       RANK_W'(5040),
      RANK_W'(40320),    RANK_W'(362880),   RANK_W'(3628800),   RANK_W'(39916800),
      RANK_W'(479001600)
   };

   // Carry and wrap signals passed from one digit cell to the next
   typedef struct packed {
      logic carry;
      logic at_end;
   } pe_chain_type;

   // One item moving down the build row
   typedef struct packed {
      logic [PERM_W-1:0] seq;
      logic [PERM_W-1:0] digits;
      logic [RANK_W-1:0] rank;
      logic              last;
   } pe_item_type;

   // Clamp the programmed size into 1..MAX_ELEMENTS
   function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] raw);
      logic [SIZE_W-1:0] n;
      n = raw;
      if (raw == '0) begin
         n = SIZE_W'(1);
      end else if (raw > SIZE_W'(MAX_ELEMENTS)) begin
         n = SIZE_W'(MAX_ELEMENTS);
      end
      return n;
   endfunction

endpackage

@@ rtl/core/permutation_enumerator.sv @@
// Top level of the permutation enumerator: digit counter row and build row.
// Each accepted request emits the next permutation of the programmed set size
// (1..12) as packed nibbles, with its rank and a last flag on rank n!-1; the
// count then wraps to rank 0. A request with restart set emits rank 0. The
// block takes one request per clock and gives one response per clock, while
// the response side does not stall: a row of eleven digit cells steps the
// mixed-radix count in the transfer cycle, and a row of eleven registered
// build cells, one per level, rebuilds the permutation. A stall on the
// response side holds the whole build row. Writing the set size clears the
// count; write it only while no request is in flight.
module permutation_enumerator
   import pe_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [SIZE_W-1:0] csr_wr_data,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_restart,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [PERM_W-1:0] rsp_perm_packed,
   output logic [RANK_W-1:0] rsp_perm_rank,
   output logic              rsp_last
);

   logic [SIZE_W-1:0] set_size_ff;
   logic [SIZE_W-1:0] set_size_in;
   logic [SIZE_W-1:0] eff_n;
   logic [RANK_W-1:0] rank_ff;
   logic [RANK_W-1:0] rank_in;
   logic [RANK_W-1:0] rank_eff;
   logic              advance;
   logic              accept;
   logic              at_end;
   logic [PERM_W-1:0] digits;

   pe_chain_type chain     [1:MAX_ELEMENTS];
   logic         pipe_valid[0:MAX_ELEMENTS-1];
   pe_item_type  pipe_item [0:MAX_ELEMENTS-1];

   // Size register
   assign set_size_in = csr_wr_en ? csr_wr_data : set_size_ff;
   assign eff_n       = eff_size(set_size_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         set_size_ff <= SIZE_RESET;
      end else begin
         set_size_ff <= set_size_in;
      end
   end

   // Handshake: the whole row moves unless the response register is stuck
   assign advance   = ~pipe_valid[MAX_ELEMENTS-1] | rsp_ready;
   assign req_ready = advance;
   assign accept    = req_valid & advance;

   // Digit counter row, fastest digit at level one
   assign chain[1].carry  = 1'b1;
   assign chain[1].at_end = 1'b1;
   assign digits[NIBBLE_W-1:0] = '0;

   for (genvar g = 1; g < MAX_ELEMENTS; g++) begin : g_digit
      pe_digit_cell u_digit (
         .clock     (clock),
         .reset     (reset),
         .clear     (csr_wr_en),
         .accept    (accept),
         .restart   (req_restart),
         .wrap      (at_end),
         .level     (SIZE_W'(g)),
         .set_size  (eff_n),
         .chain_in  (chain[g]),
         .chain_out (chain[g+1]),
         .digit     (digits[g*NIBBLE_W +: NIBBLE_W])
      );
   end

   assign at_end = chain[MAX_ELEMENTS].at_end;

   // Rank counter
   assign rank_eff = req_restart ? '0 : rank_ff;

   always_comb begin
      rank_in = rank_ff;
      if (csr_wr_en) begin
         rank_in = '0;
      end else if (accept) begin
         rank_in = at_end ? '0 : rank_eff + RANK_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rank_ff <= '0;
      end else begin
         rank_ff <= rank_in;
      end
   end

   // Feed the build row: start from the single-element list [0]
   assign pipe_valid[0]       = req_valid;
   assign pipe_item[0].seq    = '0;
   assign pipe_item[0].digits = digits;
   assign pipe_item[0].rank   = rank_eff;
   assign pipe_item[0].last   = at_end;

   for (genvar g = 1; g < MAX_ELEMENTS; g++) begin : g_build
      pe_build_cell u_build (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .level      (SIZE_W'(g)),
         .set_size   (eff_n),
         .prev_valid (pipe_valid[g-1]),
         .prev_item  (pipe_item[g-1]),
         .valid      (pipe_valid[g]),
         .item       (pipe_item[g])
      );
   end

   // Response from the last build cell
   assign rsp_valid       = pipe_valid[MAX_ELEMENTS-1];
   assign rsp_perm_packed = pipe_item[MAX_ELEMENTS-1].seq;
   assign rsp_perm_rank   = pipe_item[MAX_ELEMENTS-1].rank;
   assign rsp_last        = pipe_item[MAX_ELEMENTS-1].last;

   // Checks
   a_wrap_clears_rank: assert property (@(posedge clock) disable iff (reset)
      accept && at_end |=> rank_ff == '0)
      else $error("rank not cleared after last permutation");

   a_last_rank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_perm_rank == FACT_TABLE[eff_n] - RANK_W'(1))
      else $error("last flag on wrong rank");

   a_head_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_perm_packed[NIBBLE_W-1:0] < eff_n)
      else $error("first element out of range");

   a_restart_rank: assert property (@(posedge clock) disable iff (reset)
      accept && req_restart |=> pipe_valid[1] && pipe_item[1].rank == '0)
      else $error("restart did not emit rank zero");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while response stalled");

endmodule

@@ rtl/core/pe_digit_cell.sv @@
// One mixed-radix counter digit: holds the value prepended at its level.
module pe_digit_cell
   import pe_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                clear,
   input  logic                accept,
   input  logic                restart,
   input  logic                wrap,
   input  logic [SIZE_W-1:0]   level,
   input  logic [SIZE_W-1:0]   set_size,
   input  pe_chain_type        chain_in,
   output pe_chain_type        chain_out,
   output logic [NIBBLE_W-1:0] digit
);

   logic [NIBBLE_W-1:0] digit_ff;
   logic [NIBBLE_W-1:0] digit_in;
   logic                active;
   logic                at_max;

   // Digit seen by the current transfer, zeroed on restart
   assign digit  = restart ? '0 : digit_ff;
   assign active = level < set_size;
   assign at_max = digit == level;

   // Hand carry and wrap state to the next slower digit
   assign chain_out.carry  = chain_in.carry & at_max;
   assign chain_out.at_end = chain_in.at_end & (at_max | ~active);

   // Advance: clear or wrap zeroes, carry steps or rolls over, otherwise hold
   always_comb begin
      digit_in = digit_ff;
      if (clear) begin
         digit_in = '0;
      end else if (accept) begin
         if (wrap) begin
            digit_in = '0;
         end else if (chain_in.carry) begin
            digit_in = at_max ? '0 : digit + NIBBLE_W'(1);
         end else begin
            digit_in = digit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digit_ff <= '0;
      end else begin
         digit_ff <= digit_in;
      end
   end

endmodule

@@ rtl/core/pe_build_cell.sv @@
// One build stage: prepends its level's digit and substitutes the old value.
module pe_build_cell
   import pe_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic [SIZE_W-1:0] level,
   input  logic [SIZE_W-1:0] set_size,
   input  logic              prev_valid,
   input  pe_item_type       prev_item,
   output logic              valid,
   output pe_item_type       item
);

   logic                valid_ff;
   logic                valid_in;
   pe_item_type         item_ff;
   pe_item_type         item_in;
   logic [NIBBLE_W-1:0] d;
   logic [NIBBLE_W-1:0] v;

   // Prepend the digit; any old copy of it becomes the level value
   always_comb begin
      d       = prev_item.digits[level*NIBBLE_W +: NIBBLE_W];
      v       = '0;
      item_in = prev_item;
      if (level < set_size) begin
         item_in.seq[NIBBLE_W-1:0] = d;
         for (int k = 1; k < MAX_ELEMENTS; k++) begin
            if (k <= int'(level)) begin
               v = prev_item.seq[(k-1)*NIBBLE_W +: NIBBLE_W];
               item_in.seq[k*NIBBLE_W +: NIBBLE_W] = (v == d) ? level : v;
            end
         end
      end
      valid_in = advance ? prev_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload moves only when the row advances
   always_ff @(posedge clock) begin
      if (advance) begin
         item_ff <= item_in;
      end
   end

   assign valid = valid_ff;
   assign item  = item_ff;

endmodule
